>>> rtl/pdp11oa_pkg.sv
// ----------------------------------------------------------------------------
// PDP-11 operand address unit package
// Item types, action, status and phase codes, and addressing mode numbers.
// ----------------------------------------------------------------------------
package pdp11oa_pkg;

    localparam int unsigned ADDRESS_WIDTH_DEF = 16;
    localparam int unsigned REGISTER_COUNT    = 8;
    localparam int unsigned REG_INDEX_WIDTH   = 3;
    localparam int unsigned DATA_WIDTH        = 16;

    localparam logic [REG_INDEX_WIDTH-1:0] REG_SP = 3'd6;
    localparam logic [REG_INDEX_WIDTH-1:0] REG_PC = 3'd7;

    localparam logic [2:0] MODE_REGISTER      = 3'd0;
    localparam logic [2:0] MODE_DEFERRED      = 3'd1;
    localparam logic [2:0] MODE_AUTOINC       = 3'd2;
    localparam logic [2:0] MODE_AUTOINC_DEF   = 3'd3;
    localparam logic [2:0] MODE_AUTODEC       = 3'd4;
    localparam logic [2:0] MODE_AUTODEC_DEF   = 3'd5;
    localparam logic [2:0] MODE_INDEX         = 3'd6;
    localparam logic [2:0] MODE_INDEX_DEF     = 3'd7;

    typedef enum logic [1:0] {
        ACT_WRITE_REG = 2'd0,
        ACT_RESOLVE   = 2'd1,
        ACT_BUS_DATA  = 2'd2,
        ACT_READ_REG  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_READY   = 2'd0,
        ST_REQUEST = 2'd1,
        ST_REGVAL  = 2'd2,
        ST_ERROR   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_POINTER = 2'd1,
        PH_OFFSET  = 2'd2
    } t_phase;

    typedef struct packed {
        t_action                    action;
        logic [REG_INDEX_WIDTH-1:0] reg_index;
        logic [2:0]                 address_mode;
        logic                       byte_access;
        logic [DATA_WIDTH-1:0]      data_value;
    } t_in_item;

    typedef struct packed {
        t_status               status;
        logic [DATA_WIDTH-1:0] address;
        logic [DATA_WIDTH-1:0] reg_value;
        logic [DATA_WIDTH-1:0] pc_value;
    } t_out_item;

endpackage

>>> rtl/pdp11_operand_address_unit_top.sv
// Path: an accepted beat is held in the input register, then resolved into the result register.
// Throughput: one beat per cycle unless the output stalls; the register file is
// read, stepped and written back in the resolve stage.
// Reset (synchronous, active low) clears all eight registers to zero, returns the
// sequencer to idle and empties both the input and the result register.
// ----------------------------------------------------------------------------
// PDP-11 operand address unit
// Resolves the eight PDP-11 operand addressing modes over an 8 x 16 register
// file with R7 as the program counter; memory reads leave as request beats.
// ----------------------------------------------------------------------------
module pdp11_operand_address_unit_top
    import pdp11oa_pkg::*;
#(
    parameter int unsigned ADDRESS_WIDTH = ADDRESS_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int unsigned AW = ADDRESS_WIDTH;

    logic                       r_in_valid;
    t_in_item                   r_in;
    logic                       r_out_valid;
    t_out_item                  r_out;
    logic [AW-1:0]              r_rf [REGISTER_COUNT];
    t_phase                     r_phase;
    logic [REG_INDEX_WIDTH-1:0] r_pend_reg;
    logic [2:0]                 r_pend_mode;

    logic                       advance;
    logic                       load_in;

    t_phase                     n_phase;
    logic [REG_INDEX_WIDTH-1:0] n_pend_reg;
    logic [2:0]                 n_pend_mode;
    t_out_item                  n_out;

    logic                       wr_en;
    logic [REG_INDEX_WIDTH-1:0] wr_idx;
    logic [AW-1:0]              wr_data;

    logic [REG_INDEX_WIDTH-1:0] ridx;
    logic [AW-1:0]              rv;
    logic [AW-1:0]              pc;
    logic [AW-1:0]              pend_rv;
    logic [AW-1:0]              data_ext;
    logic                       byte_op;
    logic [AW-1:0]              step;
    logic [AW-1:0]              clr_mask;
    logic [AW-1:0]              rv_inc;
    logic [AW-1:0]              rv_dec;
    logic [AW-1:0]              offs_sum;
    logic [AW-1:0]              adr;
    logic [AW-1:0]              rv_after;
    logic [AW-1:0]              pc_after;
    t_status                    status;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign load_in    = i_in_valid && !o_in_stall;

    assign ridx     = r_in.reg_index;
    assign rv       = r_rf[ridx];
    assign pc       = r_rf[REG_PC];
    assign pend_rv  = r_rf[r_pend_reg];
    assign data_ext = AW'(r_in.data_value);
    // SP and PC always step by a word, whatever the operand size.
    assign byte_op  = r_in.byte_access && (ridx != REG_SP) && (ridx != REG_PC);
    assign step     = byte_op ? AW'(1) : AW'(2);
    assign clr_mask = byte_op ? {AW{1'b1}} : ~AW'(1);
    assign rv_inc   = rv + step;
    assign rv_dec   = rv - step;
    assign offs_sum = data_ext + pend_rv;

    // Resolve stage: decides the writeback, the next phase and the result.
    always_comb begin
        wr_en       = 1'b0;
        wr_idx      = ridx;
        wr_data     = data_ext;
        n_phase     = r_phase;
        n_pend_reg  = r_pend_reg;
        n_pend_mode = r_pend_mode;
        adr         = '0;
        status      = ST_REGVAL;
        unique case (r_in.action)
            ACT_WRITE_REG: begin
                wr_en  = 1'b1;
                status = ST_REGVAL;
            end
            ACT_RESOLVE: begin
                if (r_phase != PH_IDLE) begin
                    status = ST_ERROR;
                end else begin
                    status = ST_READY;
                    case (r_in.address_mode)
                        MODE_REGISTER: begin
                            adr = '0;
                        end
                        MODE_DEFERRED: begin
                            adr = rv & clr_mask;
                        end
                        MODE_AUTOINC: begin
                            adr     = rv & clr_mask;
                            wr_en   = 1'b1;
                            wr_data = rv_inc;
                        end
                        MODE_AUTODEC: begin
                            adr     = rv_dec & clr_mask;
                            wr_en   = 1'b1;
                            wr_data = rv_dec;
                        end
                        MODE_AUTOINC_DEF: begin
                            adr     = rv;
                            wr_en   = 1'b1;
                            wr_data = rv + AW'(2);
                            status  = ST_REQUEST;
                            n_phase = PH_POINTER;
                        end
                        MODE_AUTODEC_DEF: begin
                            adr     = rv - AW'(2);
                            wr_en   = 1'b1;
                            wr_data = rv - AW'(2);
                            status  = ST_REQUEST;
                            n_phase = PH_POINTER;
                        end
                        default: begin
                            // Index modes fetch the offset word at PC first.
                            adr     = pc;
                            wr_en   = 1'b1;
                            wr_idx  = REG_PC;
                            wr_data = pc + AW'(2);
                            status  = ST_REQUEST;
                            n_phase = PH_OFFSET;
                        end
                    endcase
                    if (r_in.address_mode == MODE_AUTOINC_DEF
                        || r_in.address_mode == MODE_AUTODEC_DEF
                        || r_in.address_mode == MODE_INDEX
                        || r_in.address_mode == MODE_INDEX_DEF) begin
                        n_pend_reg  = ridx;
                        n_pend_mode = r_in.address_mode;
                    end
                end
            end
            ACT_BUS_DATA: begin
                case (r_phase)
                    PH_POINTER: begin
                        adr     = data_ext;
                        status  = ST_READY;
                        n_phase = PH_IDLE;
                    end
                    PH_OFFSET: begin
                        adr = offs_sum;
                        if (r_pend_mode == MODE_INDEX_DEF) begin
                            status  = ST_REQUEST;
                            n_phase = PH_POINTER;
                        end else begin
                            status  = ST_READY;
                            n_phase = PH_IDLE;
                        end
                    end
                    default: begin
                        status = ST_ERROR;
                    end
                endcase
            end
            ACT_READ_REG: begin
                status = ST_REGVAL;
            end
            default: begin
                status = ST_ERROR;
            end
        endcase
    end

    always_comb begin
        pc_after = (wr_en && wr_idx == REG_PC) ? wr_data : pc;
        if (r_in.action == ACT_BUS_DATA && r_phase != PH_IDLE) begin
            rv_after = pend_rv;
        end else begin
            rv_after = (wr_en && wr_idx == ridx) ? wr_data : rv;
        end
        n_out.status    = status;
        n_out.address   = adr[DATA_WIDTH-1:0];
        n_out.reg_value = rv_after[DATA_WIDTH-1:0];
        n_out.pc_value  = pc_after[DATA_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_IDLE;
            r_pend_reg  <= '0;
            r_pend_mode <= '0;
            for (int i = 0; i < REGISTER_COUNT; i++) begin
                r_rf[i] <= '0;
            end
        end else begin
            if (load_in) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_phase     <= n_phase;
                r_pend_reg  <= n_pend_reg;
                r_pend_mode <= n_pend_mode;
                if (wr_en) begin
                    r_rf[wr_idx] <= wr_data;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_in) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
